>>> rtl/hvd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hvd_pkg: shared types and constants for the haversine distance pipeline
// Fixed-point formats, CORDIC arctangent table and register map.
// ----------------------------------------------------------------------------
package hvd_pkg;

    // CORDIC datapath width (Q30 values with gain growth and sign)
    localparam int CW = 34;

    // Square-root datapath: radicand width and number of result bits
    localparam int SQ_W     = 62;
    localparam int SQ_STEPS = 31;

    // Output range
    localparam int                DIST_W   = 26;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Register map
    localparam logic REG_RADIUS = 1'b0;
    localparam logic [23:0] RADIUS_RESET = 24'd6371000;

    // Q30 constants
    localparam logic [30:0] Q30_ONE         = 31'h4000_0000;
    localparam logic [CW-1:0] CORDIC_GAIN_INV = 34'h0_26DD_3B6A;
    localparam logic [31:0] TWO_PI_Q29      = 32'd3373259426;

    // atan(2^-i) in turns * 2^32
    localparam logic [31:0] ATAN_TURNS [0:31] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage
`default_nettype wire

>>> rtl/hvd_sincos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hvd_sincos: pipelined rotation-mode CORDIC
// Folds a binary angle into the right half plane, rotates one stage per
// cycle while enabled and unfolds the sine and cosine on the way out (Q30).
// ----------------------------------------------------------------------------
module hvd_sincos #(
    parameter int STAGES = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               valid_in,
    input  wire logic [31:0]        angle,
    output logic                    valid_out,
    output logic signed [31:0]      sin_out,
    output logic signed [31:0]      cos_out
);
    import hvd_pkg::*;

    logic signed [CW-1:0] x_reg [0:STAGES];
    logic signed [CW-1:0] y_reg [0:STAGES];
    logic signed [CW-1:0] z_reg [0:STAGES];
    logic [STAGES:0]      flip_reg;
    logic [STAGES+1:0]    valid_reg;
    logic signed [31:0]   sin_reg;
    logic signed [31:0]   cos_reg;

    logic        flip;
    logic [31:0] folded;

    // Fold quadrants two and three by a half turn
    assign flip   = angle[31] ^ angle[30];
    assign folded = {angle[31] ^ flip, angle[30:0]};

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES:0], valid_in};
        end
    end

    // Load the first stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_GAIN_INV;
            y_reg[0]    <= '0;
            z_reg[0]    <= CW'($signed(folded));
            flip_reg[0] <= flip;
        end
    end

    // Rotate one micro-step per stage
    for (genvar g = 0; g < STAGES; g++)
    begin : g_rot
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] at;

        assign xs = x_reg[g] >>> g;
        assign ys = y_reg[g] >>> g;
        assign at = $signed({{(CW-32){1'b0}}, ATAN_TURNS[g]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[g][CW-1])
                begin
                    x_reg[g+1] <= x_reg[g] - ys;
                    y_reg[g+1] <= y_reg[g] + xs;
                    z_reg[g+1] <= z_reg[g] - at;
                end
                else
                begin
                    x_reg[g+1] <= x_reg[g] + ys;
                    y_reg[g+1] <= y_reg[g] - xs;
                    z_reg[g+1] <= z_reg[g] + at;
                end
                flip_reg[g+1] <= flip_reg[g];
            end
        end
    end

    // Unfold the result
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (flip_reg[STAGES])
            begin
                cos_reg <= 32'(-x_reg[STAGES]);
                sin_reg <= 32'(-y_reg[STAGES]);
            end
            else
            begin
                cos_reg <= x_reg[STAGES][31:0];
                sin_reg <= y_reg[STAGES][31:0];
            end
        end
    end

    assign valid_out = valid_reg[STAGES+1];
    assign sin_out   = sin_reg;
    assign cos_out   = cos_reg;

endmodule
`default_nettype wire

>>> rtl/hvd_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hvd_isqrt: pipelined integer square root
// Digit-by-digit floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module hvd_isqrt (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     valid_in,
    input  wire logic [hvd_pkg::SQ_W-1:0] radicand,
    output logic                          valid_out,
    output logic [hvd_pkg::SQ_STEPS-1:0]  root
);
    import hvd_pkg::*;

    logic [SQ_W-1:0]     v_reg [0:SQ_STEPS];
    logic [SQ_W-1:0]     r_reg [0:SQ_STEPS];
    logic [SQ_STEPS:0]   valid_reg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[SQ_STEPS-1:0], valid_in};
        end
    end

    // Capture the radicand
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0] <= radicand;
            r_reg[0] <= '0;
        end
    end

    // Try one bit per stage
    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * j);
        logic [SQ_W-1:0] trial;

        assign trial = r_reg[j] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_reg[j] >= trial)
                begin
                    v_reg[j+1] <= v_reg[j] - trial;
                    r_reg[j+1] <= (r_reg[j] >> 1) + BIT;
                end
                else
                begin
                    v_reg[j+1] <= v_reg[j];
                    r_reg[j+1] <= r_reg[j] >> 1;
                end
            end
        end
    end

    assign valid_out = valid_reg[SQ_STEPS];
    assign root      = r_reg[SQ_STEPS][SQ_STEPS-1:0];

endmodule
`default_nettype wire

>>> rtl/haversine_distance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// haversine_distance: great-circle distance of two points, fixed point
// Haversine formula with CORDIC sine, cosine and arctangent and a bit-serial
// pipelined square root; result scaled by a programmable sphere radius.
// ----------------------------------------------------------------------------
// The block takes one coordinate pair per clock while in_stall is low and
// returns one distance per pair, in order. The pipe runs through the two
// CORDIC chains of one stage per iteration and the square root. Every stage
// holds under a common enable; a two-entry output buffer lets the pipe take
// one more item after the output is stalled, then in_stall rises until the
// parked item moves to the output. The radius register sits at byte address
// 0 and resets to 6371000 m.
// ----------------------------------------------------------------------------
module haversine_distance #(
    parameter int ANGLE_FRAC_BITS = 22,
    parameter int CORDIC_STAGES   = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [2:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [29:0]          first_latitude,
    input  wire logic signed [30:0]          first_longitude,
    input  wire logic signed [29:0]          second_latitude,
    input  wire logic signed [30:0]          second_longitude,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [hvd_pkg::DIST_W-1:0]       distance_m
);
    import hvd_pkg::*;

    // Degree-to-turn factor, split for two narrow multipliers
    localparam logic [63:0] DEG_K =
        ((64'd1 << (64 - ANGLE_FRAC_BITS)) + 64'd180) / 64'd360;
    localparam int KW  = $clog2(DEG_K + 64'd1);
    localparam int KLO = (KW + 1) / 2;
    localparam int KHI = KW - KLO;
    localparam logic [KLO-1:0] K_LO = DEG_K[KLO-1:0];
    localparam logic [KHI-1:0] K_HI = KHI'(DEG_K >> KLO);
    localparam int XW = 32;
    localparam int PW = XW + KLO + 1;

    logic en;
    logic push;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [23:0] radius_reg;
    logic        cfg_write;

    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_RADIUS);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_RADIUS) ? {8'd0, radius_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_write)
        begin
            radius_reg <= pwdata[23:0];
        end
    end

    // ------------------------------------------------------------------
    // Front end: differences and turn conversion
    // ------------------------------------------------------------------
    logic signed [XW-1:0] ang_reg [0:3];
    logic signed [PW-1:0] plo_reg [0:3];
    logic signed [PW-1:0] phi_reg [0:3];
    logic [31:0]          turn_reg [0:3];
    logic [2:0]           front_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= '0;
        end
        else if (en)
        begin
            front_valid_reg <= {front_valid_reg[1:0], in_valid};
        end
    end

    // Form the angle differences and capture both latitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg[0] <= XW'(second_latitude) - XW'(first_latitude);
            ang_reg[1] <= XW'(second_longitude) - XW'(first_longitude);
            ang_reg[2] <= XW'(first_latitude);
            ang_reg[3] <= XW'(second_latitude);
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_turn
        localparam int DROP = (i < 2) ? 33 : 32;
        localparam logic signed [65:0] RND = 66'sd1 <<< (DROP - 1);
        logic signed [65:0] acc;

        assign acc = (66'(phi_reg[i]) <<< KLO) + 66'(plo_reg[i]) + RND;

        // Multiply by the split factor, then recombine and round
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                plo_reg[i] <= ang_reg[i] * $signed({1'b0, K_LO});
                phi_reg[i] <= ang_reg[i] * $signed({1'b0, K_HI});
                if (DROP == 33)
                begin
                    turn_reg[i] <= {1'b0, acc[63:33]};
                end
                else
                begin
                    turn_reg[i] <= acc[63:32];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sines and cosines
    // ------------------------------------------------------------------
    logic signed [31:0] sin_v [0:3];
    logic signed [31:0] cos_v [0:3];
    logic               sc_valid;

    hvd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlat (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(front_valid_reg[2]),
        .angle(turn_reg[0]), .valid_out(sc_valid),
        .sin_out(sin_v[0]), .cos_out(cos_v[0])
    );

    for (genvar i = 1; i < 4; i++)
    begin : g_sc
        hvd_sincos #(.STAGES(CORDIC_STAGES)) u_sc (
            .clk(clk), .rst_n(rst_n), .en(en), .valid_in(front_valid_reg[2]),
            .angle(turn_reg[i]), .valid_out(),
            .sin_out(sin_v[i]), .cos_out(cos_v[i])
        );
    end

    // ------------------------------------------------------------------
    // Haversine term
    // ------------------------------------------------------------------
    localparam logic signed [63:0] Q_RND = 64'sd1 <<< 29;

    logic signed [31:0] sq_dlat_reg;
    logic signed [31:0] sq_dlon_reg;
    logic signed [31:0] cc_reg;
    logic signed [31:0] sq_dlat2_reg;
    logic signed [31:0] ccsq_reg;
    logic [30:0]        a_reg;
    logic [2:0]         hav_valid_reg;

    logic signed [63:0] sq_dlat_p;
    logic signed [63:0] sq_dlon_p;
    logic signed [63:0] cc_p;
    logic signed [63:0] ccsq_p;
    logic signed [32:0] a_sum;

    assign sq_dlat_p = sin_v[0] * sin_v[0] + Q_RND;
    assign sq_dlon_p = sin_v[1] * sin_v[1] + Q_RND;
    assign cc_p      = cos_v[2] * cos_v[3] + Q_RND;
    assign ccsq_p    = cc_reg * sq_dlon_reg + Q_RND;
    assign a_sum     = 33'(sq_dlat2_reg) + 33'(ccsq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hav_valid_reg <= '0;
        end
        else if (en)
        begin
            hav_valid_reg <= {hav_valid_reg[1:0], sc_valid};
        end
    end

    // Square, cross-multiply, then sum and clamp to [0, 1]
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_dlat_reg  <= 32'(sq_dlat_p >>> 30);
            sq_dlon_reg  <= 32'(sq_dlon_p >>> 30);
            cc_reg       <= 32'(cc_p >>> 30);
            sq_dlat2_reg <= sq_dlat_reg;
            ccsq_reg     <= 32'(ccsq_p >>> 30);
            if (a_sum[32])
            begin
                a_reg <= '0;
            end
            else if (a_sum > 33'(Q30_ONE))
            begin
                a_reg <= Q30_ONE;
            end
            else
            begin
                a_reg <= a_sum[30:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Square roots of a and 1 - a
    // ------------------------------------------------------------------
    logic [SQ_STEPS-1:0] ra;
    logic [SQ_STEPS-1:0] rb;
    logic                sq_valid;
    logic [30:0]         a_comp;

    assign a_comp = Q30_ONE - a_reg;

    hvd_isqrt u_sqrt_a (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(hav_valid_reg[2]),
        .radicand(SQ_W'({a_reg, 30'd0})), .valid_out(sq_valid), .root(ra)
    );

    hvd_isqrt u_sqrt_b (
        .clk(clk), .rst_n(rst_n), .en(en), .valid_in(hav_valid_reg[2]),
        .radicand(SQ_W'({a_comp, 30'd0})), .valid_out(), .root(rb)
    );

    // ------------------------------------------------------------------
    // Vectoring CORDIC for the central angle
    // ------------------------------------------------------------------
    logic signed [CW-1:0] vx_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] vy_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0] vz_reg [0:CORDIC_STAGES];
    logic [CORDIC_STAGES:0] vec_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_valid_reg <= '0;
        end
        else if (en)
        begin
            vec_valid_reg <= {vec_valid_reg[CORDIC_STAGES-1:0], sq_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg[0] <= $signed({{(CW-SQ_STEPS){1'b0}}, rb});
            vy_reg[0] <= $signed({{(CW-SQ_STEPS){1'b0}}, ra});
            vz_reg[0] <= '0;
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_vec
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [CW-1:0] at;
        logic                 y_pos;

        assign xs    = vx_reg[g] >>> g;
        assign ys    = vy_reg[g] >>> g;
        assign at    = $signed({{(CW-32){1'b0}}, ATAN_TURNS[g]});
        assign y_pos = !vy_reg[g][CW-1] && (vy_reg[g] != '0);

        // Rotate toward the x axis and accumulate the angle
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_pos)
                begin
                    vx_reg[g+1] <= vx_reg[g] + ys;
                    vy_reg[g+1] <= vy_reg[g] - xs;
                    vz_reg[g+1] <= vz_reg[g] + at;
                end
                else
                begin
                    vx_reg[g+1] <= vx_reg[g] - ys;
                    vy_reg[g+1] <= vy_reg[g] + xs;
                    vz_reg[g+1] <= vz_reg[g] - at;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Radians and scaling by the radius
    // ------------------------------------------------------------------
    logic [31:0] zc;
    logic [63:0] rad_p;
    logic [57:0] dist_p;
    logic [33:0] rad_reg;
    logic [27:0] d_reg;
    logic [1:0]  tail_valid_reg;
    logic [DIST_W-1:0] d_sat;

    assign zc     = vz_reg[CORDIC_STAGES][CW-1] ? 32'd0 : vz_reg[CORDIC_STAGES][31:0];
    assign rad_p  = zc * TWO_PI_Q29 + 64'(1 << 29);
    assign dist_p = 58'(radius_reg) * 58'(rad_reg) + 58'(1 << 29);
    assign d_sat  = (d_reg > 28'(DIST_MAX)) ? DIST_MAX : d_reg[DIST_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_valid_reg <= '0;
        end
        else if (en)
        begin
            tail_valid_reg <= {tail_valid_reg[0], vec_valid_reg[CORDIC_STAGES]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= rad_p[63:30];
            d_reg   <= dist_p[57:30];
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid entry
    // ------------------------------------------------------------------
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic [DIST_W-1:0] out_data_reg;
    logic [DIST_W-1:0] skid_data_reg;
    logic              out_take;

    assign en       = !skid_valid_reg;
    assign push     = en && tail_valid_reg[1];
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Move data into the output or park it in the skid entry
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_data_reg <= d_sat;
            end
            else
            begin
                out_data_reg <= d_sat;
            end
        end
    end

    assign in_stall   = skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign distance_m = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds an item while the output is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && push) |=> skid_valid_reg)
        else $error("item pushed into a stalled output was not parked");

    a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid entry filled without an output stall");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (radius_reg == $past(pwdata[23:0])))
        else $error("radius register did not take the written value");

endmodule
`default_nettype wire

>>> verif/haversine_distance_checker.sv
// ----------------------------------------------------------------------------
// haversine_distance_checker: distance predictor and result comparator
// Watches the input and output channels of the haversine distance block,
// computes the expected distance of every accepted item and compares it with
// the distance the block returns, in order.
// ----------------------------------------------------------------------------
module haversine_distance_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [29:0]            first_latitude,
    input  logic signed [30:0]            first_longitude,
    input  logic signed [29:0]            second_latitude,
    input  logic signed [30:0]            second_longitude,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [hvd_pkg::DIST_W-1:0]    distance_m,
    input  logic [23:0]                   radius_m,
    output int                            fail_count,
    output int                            pending
);
    import hvd_pkg::*;

    localparam int FRAC_BITS = 22;
    localparam int STAGES    = 24;

    // degrees to binary angle factor: round(2^(64-FRAC_BITS)/360)
    localparam longint unsigned TURN_K = ((64'd1 << (64 - FRAC_BITS)) + 64'd180) / 64'd360;

    logic [DIST_W-1:0] dist_queue [$];

    // round-half-up Q30 product
    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [31:0] deg_to_turns(longint x, int drop);
        longint unsigned p;
        p = longint'(x) * TURN_K + (64'd1 << (drop - 1));
        return 32'(p >> drop);
    endfunction

    // rotation CORDIC with quadrant fold
    function automatic void rotate(input logic [31:0] th, output longint s,
                                   output longint c);
        logic flip;
        longint x, y, z, t;
        flip = (th[31:30] == 2'd1) || (th[31:30] == 2'd2);
        x = longint'(CORDIC_GAIN_INV);
        y = 0;
        if (flip)
            th = th + 32'h8000_0000;
        z = longint'($signed(th));
        for (int i = 0; i < STAGES; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_TURNS[i]);
            end
            else
            begin
                t = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_TURNS[i]);
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint vector_angle(longint x, longint y);
        longint z, t;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            if (y > 0)
            begin
                t = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_TURNS[i]);
            end
            else
            begin
                t = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_TURNS[i]);
            end
            x = t;
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] great_circle(longint lat1, longint lon1,
                                                       longint lat2, longint lon2,
                                                       logic [23:0] radius);
        longint sdl, cdl, sdn, cdn, s1, c1, s2, c2, h, ra, rb, z, rad;
        longint unsigned d;
        rotate(deg_to_turns(lat2 - lat1, 33), sdl, cdl);
        rotate(deg_to_turns(lon2 - lon1, 33), sdn, cdn);
        rotate(deg_to_turns(lat1, 32), s1, c1);
        rotate(deg_to_turns(lat2, 32), s2, c2);
        h = q30_mul(sdl, sdl) + q30_mul(q30_mul(c1, c2), q30_mul(sdn, sdn));
        // clamp haversine term to [0, 1]
        if (h < 0)
            h = 0;
        if (h > (64'sd1 <<< 30))
            h = 64'sd1 <<< 30;
        ra = longint'(int_sqrt(longint'(h) << 30));
        rb = longint'(int_sqrt(longint'((64'sd1 <<< 30) - h) << 30));
        z = vector_angle(rb, ra);
        if (z < 0)
            z = 0;
        rad = (z * longint'(TWO_PI_Q29) + (64'sd1 <<< 29)) >>> 30;
        d = (longint'(radius) * rad + (64'd1 << 29)) >> 30;
        if (d > longint'(DIST_MAX))
            d = longint'(DIST_MAX);
        return DIST_W'(d);
    endfunction

    assign pending = dist_queue.size();

    // predict on input accept, compare on output accept
    always @(posedge clk or negedge rst_n)
    begin
        logic [DIST_W-1:0] want;
        if (!rst_n)
        begin
            fail_count <= 0;
            dist_queue.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                dist_queue.push_back(great_circle(first_latitude, first_longitude,
                                                  second_latitude, second_longitude,
                                                  radius_m));
            if (out_valid && !out_stall)
            begin
                if (dist_queue.size() == 0)
                begin
                    $display("%0t: unexpected distance %0d", $time, distance_m);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = dist_queue.pop_front();
                    if (want !== distance_m)
                    begin
                        $display("%0t: distance_m expected %0d actual %0d",
                                 $time, want, distance_m);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> verif/haversine_distance_tb.sv
// ----------------------------------------------------------------------------
// haversine_distance_tb: stimulus and verdict for the haversine distance block
// Programs several sphere radii, sends directed and random coordinate pairs
// with random gaps and output stalls, and relies on the checker for compares.
// ----------------------------------------------------------------------------
module haversine_distance_tb;
    import hvd_pkg::*;

    localparam int  LATENCY   = 92;
    localparam int  N_RANDOM  = 1800;
    localparam int  LAT_MAX   = 377487360;
    localparam int  LON_MAX   = 754974720;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0, in_stall;
    logic signed [29:0] first_latitude = '0, second_latitude = '0;
    logic signed [30:0] first_longitude = '0, second_longitude = '0;
    logic out_valid, out_stall = 1'b0;
    logic [DIST_W-1:0] distance_m;
    logic [23:0] radius_m = RADIUS_RESET;
    int fail_count, pending;
    int hold_off = 0;
    int rx_wait = 0;
    longint cycles = 0;

    haversine_distance dut (.*);

    haversine_distance_checker checker_i (.*);

    always #10 clk = ~clk;

    // abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("haversine_distance_tb: FAIL");
            $finish;
        end
    end

    // receiver: random wait per item, plus a long hold-off on request
    always @(posedge clk)
    begin
        int w;
        if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else if (rx_wait > 0)
        begin
            out_stall <= 1'b1;
            rx_wait <= rx_wait - 1;
        end
        else if (out_valid && !out_stall)
        begin
            w = $urandom_range(0, 6);
            out_stall <= (w != 0);
            rx_wait <= (w != 0) ? w - 1 : 0;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic write_radius(input logic [23:0] r);
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_RADIUS, 2'b00}; pwdata <= {8'h0, r};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        radius_m <= r;
    endtask

    task automatic send_pair(input int la1, input int lo1, input int la2, input int lo2);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        // idle between items
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        first_latitude <= 30'(la1); first_longitude <= 31'(lo1);
        second_latitude <= 30'(la2); second_longitude <= 31'(lo2);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // drain results, then let the pipe settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    function automatic int rand_field(int w, int lim);
        int v;
        v = int'($urandom);
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? lim : -lim;
            1: return (v <<< (32 - w)) >>> (32 - w);
            default: return int'($urandom_range(0, 2 * lim)) - lim;
        endcase
    endfunction

    task automatic random_pair();
        int la1, lo1;
        la1 = rand_field(30, LAT_MAX);
        lo1 = rand_field(31, LON_MAX);
        // often a nearby second point, for short distances
        if ($urandom_range(0, 3) == 0)
            send_pair(la1, lo1, la1 + int'($urandom_range(0, 4000)) - 2000,
                      lo1 + int'($urandom_range(0, 4000)) - 2000);
        else
            send_pair(la1, lo1, rand_field(30, LAT_MAX), rand_field(31, LON_MAX));
    endtask

    initial
    begin
        logic [23:0] radii [4];
        radii = '{24'd1, 24'hFFFFFF, 24'd6371000, 24'd0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, antipodes, identical points, wrap, all-ones bits
        send_pair(0, 0, 0, 0);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(0, -LON_MAX, 0, LON_MAX);
        send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_pair(-(1 << 29), -(1 << 30), (1 << 29) - 1, (1 << 30) - 1);
        send_pair((1 << 29) - 1, (1 << 30) - 1, -(1 << 29), -(1 << 30));
        send_pair(-1, -1, -1, -1);
        send_pair(0, 0, 1, 1);
        send_pair(12345678, 0, 12345678, 754974720 / 2);
        send_pair(LAT_MAX / 2, LON_MAX / 3, -LAT_MAX / 4, -LON_MAX / 5);
        drain();

        // radius extremes, then zero radius (ignored range check here)
        foreach (radii[k])
        begin
            write_radius(radii[k]);
            send_pair(LAT_MAX, 0, -LAT_MAX, 0);
            send_pair(0, 0, 0, LON_MAX);
            for (int j = 0; j < 40; j++)
                random_pair();
            drain();
        end
        write_radius(RADIUS_RESET);

        // back pressure: hold output long while items keep coming
        hold_off <= 1000;
        for (int j = 0; j < 150; j++)
            random_pair();

        for (int j = 0; j < N_RANDOM - 310; j++)
        begin
            if (j == 700)
            begin
                drain();
                write_radius(24'd10000000);
            end
            random_pair();
        end
        drain();

        if (fail_count == 0)
            $display("haversine_distance_tb: PASS");
        else
            $display("haversine_distance_tb: FAIL");
        $finish;
    end
endmodule
